@@ sv/b64enc_pkg.sv @@
// ---------------------------------------------------------------------------
// b64enc_pkg
// shared types, constants and the character table of the base64 encoder
// ---------------------------------------------------------------------------
package b64enc_pkg;

    localparam int GQ_DEPTH_DEF = 2;

    localparam logic [6:0] PAD_INDEX   = 7'h40;
    localparam logic [6:0] PAD_CHAR    = 7'h3D;

    // one complete or closing group handed from front to back
    typedef struct packed {
        logic [23:0] group;   // bytes, oldest in the top bits
        logic [1:0]  total;   // bytes supplied (1..3)
        logic        last;    // group closed by the final byte
    } grp_desc_t;

    // sextet index (0..64) to ascii character
    function automatic logic [6:0] b64_char(input logic [6:0] idx);
        logic [6:0] ch;
        case (idx) inside
            [7'd0:7'd25]:  ch = 7'(7'h41 + idx);
            [7'd26:7'd51]: ch = 7'(7'h61 + (idx - 7'd26));
            [7'd52:7'd61]: ch = 7'(7'h30 + (idx - 7'd52));
            7'd62:         ch = 7'h2B;
            7'd63:         ch = 7'h2F;
            default:       ch = PAD_CHAR;
        endcase
        return ch;
    endfunction

endpackage

@@ sv/b64enc_front.sv @@
// ---------------------------------------------------------------------------
// b64enc_front
// gathers bytes into groups and hands closed groups to the group queue
// ---------------------------------------------------------------------------
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_take,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        grp_push,
    output grp_desc_t   grp_data
);

    logic [15:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic [1:0]  held;
    logic        store;

    always_comb
    begin
        held  = (pending_count_reg > 2'd2) ? 2'd2 : pending_count_reg;
        store = !end_of_message && (held < 2'd2);

        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        grp_push           = 1'b0;
        grp_data.last      = end_of_message;
        grp_data.total     = 2'(held + 2'd1);

        case (held)
            2'd2:    grp_data.group = {pending_bytes_reg, data_byte};
            2'd1:    grp_data.group = {pending_bytes_reg[7:0], data_byte, 8'h00};
            default: grp_data.group = {data_byte, 16'h0000};
        endcase

        if (in_take)
        begin
            if (store)
            begin
                pending_bytes_next = {pending_bytes_reg[7:0], data_byte};
                pending_count_next = 2'(held + 2'd1);
            end
            else
            begin
                grp_push           = 1'b1;
                pending_bytes_next = 16'h0000;
                pending_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bytes_reg <= 16'h0000;
            pending_count_reg <= 2'd0;
        end
        else
        begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

@@ sv/b64enc_gq.sv @@
// ---------------------------------------------------------------------------
// b64enc_gq
// short queue of group descriptors between front and back
// ---------------------------------------------------------------------------
module b64enc_gq
    import b64enc_pkg::*;
#(
    parameter int DEPTH = GQ_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  grp_desc_t wr_data,
    input  logic      pop,
    output grp_desc_t rd_data,
    output logic      full,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    grp_desc_t         slots [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slots[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= CW'(count_reg + 1'b1);
            else if (do_pop && !do_push)
                count_reg <= CW'(count_reg - 1'b1);
        end
    end

endmodule

@@ sv/b64enc_back.sv @@
// ---------------------------------------------------------------------------
// b64enc_back
// turns one group into four characters, one per cycle while pop is high, held for the receiver
// ---------------------------------------------------------------------------
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  grp_desc_t grp_data,
    input  logic      grp_empty,
    output logic      grp_pop,
    input  logic      pop,
    output logic      empty,
    output logic [6:0] code_char,
    output logic      last_char
);

    grp_desc_t  cur_reg;
    logic       valid_reg;
    logic [1:0] pos_reg;
    logic       out_take;
    logic       slot_free;
    logic [5:0] sextet;
    logic [6:0] idx;

    assign empty     = !valid_reg;
    assign out_take  = pop && valid_reg;
    assign slot_free = !valid_reg || (out_take && pos_reg == 2'd3);
    assign grp_pop   = slot_free && !grp_empty;

    always_comb
    begin
        case (pos_reg)
            2'd0:    sextet = cur_reg.group[23:18];
            2'd1:    sextet = cur_reg.group[17:12];
            2'd2:    sextet = cur_reg.group[11:6];
            default: sextet = cur_reg.group[5:0];
        endcase
        idx       = (pos_reg > cur_reg.total) ? PAD_INDEX : {1'b0, sextet};
        code_char = b64_char(idx);
        last_char = cur_reg.last && (pos_reg == 2'd3);
    end

    always_ff @(posedge clk)
    begin
        if (grp_pop)
            cur_reg <= grp_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end
        else if (slot_free)
        begin
            valid_reg <= !grp_empty;
            pos_reg   <= 2'd0;
        end
        else if (out_take)
        begin
            pos_reg <= 2'(pos_reg + 2'd1);
        end
    end

endmodule

@@ sv/base64_stream_encoder_core.sv @@
// ---------------------------------------------------------------------------
// base64_stream_encoder_core
// streaming base64 encoder, one byte in per item, one character out per item
// ---------------------------------------------------------------------------
// input channel: push with data_byte and end_of_message, taken when full is
// low; end_of_message marks the final byte of a message
// output channel: while empty is low, code_char and last_char show the oldest
// character; pop takes it; last_char marks the final character of a message
// every third byte, or the final byte, closes a group that yields four
// characters, '=' standing in for positions past the supplied bytes
// with the back end idle, a closing byte is written into the group queue when
// it is taken, then loaded from there into the output register, where its
// first character shows
// throughput: a byte every cycle at the input while full is low; the back end
// sends one character per cycle while pop is high, so a steady stream is paced
// by the back end and its single output register
// when the receiver stalls, the current character holds and closed groups
// collect in the group queue; full rises once the queue is full, and then
// no item is taken even if it would only be stored
// reset clears the held bytes and empties the queue and the output register at once
// ---------------------------------------------------------------------------
module base64_stream_encoder_core
    import b64enc_pkg::*;
#(
    parameter int GQ_DEPTH = GQ_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] code_char,
    output logic       last_char
);

    logic      in_take;
    logic      grp_push;
    logic      grp_pop;
    logic      grp_empty;
    grp_desc_t grp_wr;
    grp_desc_t grp_rd;

    // an item is taken whenever the group queue has room
    assign in_take = push && !full;

    // front: byte gathering
    b64enc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_take        (in_take),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .grp_push       (grp_push),
        .grp_data       (grp_wr)
    );

    // decoupling queue of closed groups
    b64enc_gq #(
        .DEPTH (GQ_DEPTH)
    ) u_gq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (grp_push),
        .wr_data (grp_wr),
        .pop     (grp_pop),
        .rd_data (grp_rd),
        .full    (full),
        .empty   (grp_empty)
    );

    // back: character serialiser with output register
    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_data  (grp_rd),
        .grp_empty (grp_empty),
        .grp_pop   (grp_pop),
        .pop       (pop),
        .empty     (empty),
        .code_char (code_char),
        .last_char (last_char)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming base64 encoder
// ---------------------------------------------------------------------------
// bytes go in through the push/full side and characters come back through
// the empty/pop side; a local encoder model tracks the held bytes and
// queues the four characters of every closed group. a short table of
// hand-picked bytes comes first, then random messages under four idling
// patterns, draining the encoder fully between patterns
// ---------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS  = 430;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int DIR_ROWS      = 21;

    // sextet index 0..63 to character, index 64 is the pad
    localparam logic [8*65-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
    localparam logic [6:0] PAD_SEXTET = 7'h40;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       push           = 1'b0;
    logic       pop            = 1'b0;
    logic [7:0] data_byte      = 8'h00;
    logic       end_of_message = 1'b0;
    wire        full;
    wire        empty;
    wire  [6:0] code_char;
    wire        last_char;

    // one character the encoder owes us
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } enc_char_t;

    // one row of the directed table; text is only meaningful where typed is set
    typedef struct packed {
        logic [7:0]  data;
        logic        eom;
        logic        typed;
        logic [31:0] text;
    } byte_row_t;

    enc_char_t   encoded_chars[$];
    byte_row_t   byte_rows[DIR_ROWS];
    logic [15:0] held_bytes  = 16'h0000;
    logic [1:0]  held_count  = 2'd0;
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;

    base64_stream_encoder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .code_char      (code_char),
        .last_char      (last_char)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [6:0] sextet_char(input logic [6:0] idx);
        return B64_ALPHABET[8 * (64 - int'(idx)) +: 7];
    endfunction

    // encoder model: holds bytes until a group closes, then yields four chars
    task automatic encode_byte(input logic [7:0] b, input logic eom,
                               output bit closed, output logic [27:0] chars);
        logic [1:0]  held;
        logic [23:0] group;
        logic [6:0]  idx;
        int          total;
        begin
            held   = (held_count > 2'd2) ? 2'd2 : held_count;
            closed = eom || (held == 2'd2);
            chars  = '0;
            if (!closed)
            begin
                held_bytes = {held_bytes[7:0], b};
                held_count = held + 2'd1;
            end
            else
            begin
                total = int'(held) + 1;
                case (held)
                    2'd2:    group = {held_bytes, b};
                    2'd1:    group = {held_bytes[7:0], b, 8'h00};
                    default: group = {b, 16'h0000};
                endcase
                for (int k = 0; k < 4; k++)
                begin
                    // positions past the supplied bytes become pad
                    idx = (k > total) ? PAD_SEXTET : {1'b0, group[(3 - k) * 6 +: 6]};
                    chars[27 - 7 * k -: 7] = sextet_char(idx);
                end
                held_bytes = 16'h0000;
                held_count = 2'd0;
            end
        end
    endtask

    task automatic queue_group(input logic [27:0] chars, input logic eom);
        enc_char_t c;
        begin
            for (int k = 0; k < 4; k++)
            begin
                c.ch   = chars[27 - 7 * k -: 7];
                c.last = eom && (k == 3);
                encoded_chars.push_back(c);
            end
        end
    endtask

    // offer one item, wait for it to be taken, then update the model
    task automatic send_byte(input logic [7:0] b, input logic eom,
                             input logic typed, input logic [31:0] text);
        bit          closed;
        logic [27:0] chars;
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            push           <= 1'b1;
            data_byte      <= b;
            end_of_message <= eom;
            @(posedge clk);
            while (full)
                @(posedge clk);
            encode_byte(b, eom, closed, chars);
            if (closed)
            begin
                // hand-typed characters take the place of the model's
                if (typed)
                    for (int k = 0; k < 4; k++)
                        chars[27 - 7 * k -: 7] = text[30 - 8 * k -: 7];
                queue_group(chars, eom);
            end
        end
    endtask

    // hold the sender off until every owed character has come back
    task automatic drain_encoder();
        begin
            push <= 1'b0;
            while (encoded_chars.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // random messages, mostly short, now and then a long one
    task automatic send_messages(input int budget);
        int         sent;
        int         len;
        logic [7:0] b;
        begin
            sent = 0;
            while (sent < budget)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(b, i == len - 1, 1'b0, 32'h0);
                end
                sent += len;
            end
        end
    endtask

    // result side: check every taken character, then choose pop for next cycle
    initial
    begin
        enc_char_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (encoded_chars.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected char: got %h last %b", code_char, last_char);
                end
                else
                begin
                    want = encoded_chars.pop_front();
                    if (code_char !== want.ch || last_char !== want.last)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("char mismatch: expected %h last %b, got %h last %b",
                                     want.ch, want.last, code_char, last_char);
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    initial
    begin
        // single bytes, full groups of the extremes, pad cases, '+' and '/'
        byte_rows[0]  = {8'h00, 1'b1, 1'b1, "AA=="};
        byte_rows[1]  = {8'hFF, 1'b1, 1'b1, "/w=="};
        byte_rows[2]  = {8'hFF, 1'b0, 1'b0, 32'h0};
        byte_rows[3]  = {8'hFF, 1'b1, 1'b1, "//8="};
        byte_rows[4]  = {8'h00, 1'b0, 1'b0, 32'h0};
        byte_rows[5]  = {8'h00, 1'b0, 1'b0, 32'h0};
        byte_rows[6]  = {8'h00, 1'b0, 1'b1, "AAAA"};
        byte_rows[7]  = {8'hFF, 1'b0, 1'b0, 32'h0};
        byte_rows[8]  = {8'hFF, 1'b0, 1'b0, 32'h0};
        byte_rows[9]  = {8'hFF, 1'b1, 1'b1, "////"};
        byte_rows[10] = {8'h4D, 1'b0, 1'b0, 32'h0};
        byte_rows[11] = {8'h61, 1'b0, 1'b0, 32'h0};
        byte_rows[12] = {8'h6E, 1'b1, 1'b1, "TWFu"};
        byte_rows[13] = {8'h80, 1'b1, 1'b1, "gA=="};
        byte_rows[14] = {8'hF8, 1'b1, 1'b0, 32'h0};
        byte_rows[15] = {8'hA5, 1'b0, 1'b0, 32'h0};
        byte_rows[16] = {8'h5A, 1'b0, 1'b0, 32'h0};
        byte_rows[17] = {8'h3C, 1'b0, 1'b0, 32'h0};
        byte_rows[18] = {8'hC3, 1'b1, 1'b0, 32'h0};
        byte_rows[19] = {8'hFB, 1'b0, 1'b0, 32'h0};
        byte_rows[20] = {8'hEF, 1'b1, 1'b0, 32'h0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table with both sides flowing freely
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(byte_rows[r].data, byte_rows[r].eom, byte_rows[r].typed,
                      byte_rows[r].text);
        drain_encoder();

        // random messages: no idling, idle sender, stalling receiver, both
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; pop_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  pop_stall_pct = 62; end
                default: begin send_idle_pct = 20; pop_stall_pct = 20; end
            endcase
            send_messages(PHASE_ITEMS);
            drain_encoder();
        end

        if (error_count == 0 && encoded_chars.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/b64enc_pkg.sv
sv/b64enc_front.sv
sv/b64enc_gq.sv
sv/b64enc_back.sv
sv/base64_stream_encoder_core.sv
tb/tb_top.sv
